FILE: rtl/lpfs_pkg.sv
// Package for the length-prefixed frame splitter: parser phases, result codes
// and the result and queue types shared by the front, queue, back and top level.
// Depends on nothing.
`default_nettype none

package lpfs_pkg;

	// Parser phase of the front part.
	typedef enum logic [2:0] {
		PH_LEN_LO,
		PH_LEN_HI,
		PH_ID_LO,
		PH_ID_HI,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	// Input beat kinds.
	localparam logic IN_DATA  = 1'b0;
	localparam logic IN_CLEAR = 1'b1;

	// Result kinds.
	localparam logic [1:0] OK_PAYLOAD = 2'd0;
	localparam logic [1:0] OK_EMPTY   = 2'd1;
	localparam logic [1:0] OK_ERROR   = 2'd2;

	// Error codes.
	localparam logic ERR_SHORT     = 1'b0;
	localparam logic ERR_TOO_LARGE = 1'b1;

	// The length field counts the two id bytes; the frame total adds the two
	// length bytes on top of that.
	localparam logic [15:0] ID_BYTES     = 16'd2;
	localparam logic [16:0] LEN_BYTES    = 17'd2;
	localparam logic [16:0] MAX_TOTAL_RST = 17'd4096;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] id;
		logic [7:0]  data;
		logic        last;
		logic        code;
	} res_t;

	// One queue entry offered by a producer, with its valid flag.
	typedef struct packed {
		logic vld;
		res_t res;
	} q_item_t;

	// Queue fill status.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lpfs_front.sv
// Front part of the frame splitter: accepts input beats, tracks the header
// phase, length, id and remaining count, and pushes results to the queue.
// Depends on lpfs_pkg.
`default_nettype none

module lpfs_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic                in_kind,
	input  wire logic [7:0]          in_byte,
	input  wire logic [16:0]         max_total,
	output lpfs_pkg::q_item_t        push
);

	lpfs_pkg::phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] id_q, id_d;
	logic [15:0] left_q, left_d;
	logic [15:0] len_full;
	logic [15:0] id_full;
	logic [16:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpfs_pkg::PH_LEN_LO;
			len_q   <= '0;
			id_q    <= '0;
			left_q  <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			id_q    <= id_d;
			left_q  <= left_d;
		end
	end

	assign len_full = {in_byte, len_q[7:0]};
	assign id_full  = {in_byte, id_q[7:0]};
	assign total    = {1'b0, len_full} + lpfs_pkg::LEN_BYTES;

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		id_d    = id_q;
		left_d  = left_q;
		push    = '0;
		if (accept) begin
			if (in_kind == lpfs_pkg::IN_CLEAR) begin
				phase_d = lpfs_pkg::PH_LEN_LO;
				len_d   = '0;
				id_d    = '0;
				left_d  = '0;
			end else begin
				case (phase_q)
					lpfs_pkg::PH_LEN_LO: begin
						len_d   = {8'd0, in_byte};
						phase_d = lpfs_pkg::PH_LEN_HI;
					end
					lpfs_pkg::PH_LEN_HI: begin
						len_d = len_full;
						if (len_full < lpfs_pkg::ID_BYTES) begin
							phase_d       = lpfs_pkg::PH_ERROR;
							push.vld      = 1'b1;
							push.res.kind = lpfs_pkg::OK_ERROR;
							push.res.code = lpfs_pkg::ERR_SHORT;
						end else if (total > max_total) begin
							phase_d       = lpfs_pkg::PH_ERROR;
							push.vld      = 1'b1;
							push.res.kind = lpfs_pkg::OK_ERROR;
							push.res.code = lpfs_pkg::ERR_TOO_LARGE;
						end else begin
							phase_d = lpfs_pkg::PH_ID_LO;
						end
					end
					lpfs_pkg::PH_ID_LO: begin
						id_d    = {8'd0, in_byte};
						phase_d = lpfs_pkg::PH_ID_HI;
					end
					lpfs_pkg::PH_ID_HI: begin
						id_d = id_full;
						if (len_q == lpfs_pkg::ID_BYTES) begin
							phase_d       = lpfs_pkg::PH_LEN_LO;
							left_d        = '0;
							push.vld      = 1'b1;
							push.res.kind = lpfs_pkg::OK_EMPTY;
							push.res.id   = id_full;
							push.res.last = 1'b1;
						end else begin
							left_d  = len_q - lpfs_pkg::ID_BYTES;
							phase_d = lpfs_pkg::PH_PAYLOAD;
						end
					end
					lpfs_pkg::PH_PAYLOAD: begin
						left_d        = left_q - 16'd1;
						push.vld      = 1'b1;
						push.res.kind = lpfs_pkg::OK_PAYLOAD;
						push.res.id   = id_q;
						push.res.data = in_byte;
						push.res.last = (left_q == 16'd1);
						if (left_q == 16'd1) begin
							phase_d = lpfs_pkg::PH_LEN_LO;
						end
					end
					lpfs_pkg::PH_ERROR: begin
						// Data beats are dropped until a clear arrives.
					end
					default: begin
						phase_d = lpfs_pkg::PH_LEN_LO;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpfs_queue.sv
// Short first-in first-out queue of results between the front and back parts.
// Depends on lpfs_pkg.
`default_nettype none

module lpfs_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpfs_pkg::q_item_t push,
	input  wire logic              pop,
	output lpfs_pkg::q_item_t      head,
	output lpfs_pkg::q_stat_t      stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	lpfs_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == FULL_CNT);
	assign do_push    = push.vld && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head.vld   = !stat.empty;
	assign head.res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpfs_back.sv
// Back part of the frame splitter: the output register that presents queued
// results to the receiver and takes the next one as the current beat leaves.
// Depends on lpfs_pkg.
`default_nettype none

module lpfs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpfs_pkg::q_item_t head,
	output logic                   pop,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output lpfs_pkg::res_t         out_res
);

	logic           vld_q;
	lpfs_pkg::res_t res_q;

	// Load whenever the register is empty or its beat is taken this cycle.
	assign pop = head.vld && (!vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || out_ready) begin
			vld_q <= head.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head.res;
		end
	end

	assign out_valid = vld_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_frame_splitter.sv
// Top level of the length-prefixed frame splitter: input channel, configuration
// register, front parser, result queue and output register, plus assertions.
// Depends on lpfs_pkg, lpfs_front, lpfs_queue and lpfs_back.
//
// Usage: the input channel carries one stream byte per beat in s_axis_tdata,
// or a clear beat when s_axis_tuser is high. Each frame is a 16-bit
// little-endian length, a 16-bit little-endian message id and length-2
// payload bytes. Every payload byte leaves as one output beat tagged with the
// message id, the final one with m_axis_tlast set. A frame without payload
// gives one empty-frame beat; a bad length gives one error beat, after which
// data beats are dropped until a clear beat arrives.
// Throughput is one input beat per cycle while s_axis_tready is high; the
// parser updates its state on every accepted beat. A result is first written
// into the queue, then loaded from the queue into the output register.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue;
// s_axis_tready falls only once the queue is full, and no beat is lost.
// Reset clears the parser to wait for a length low byte, empties the queue
// and the output register, and sets the maximum frame total to 4096.
// cfg_wr_data may be written at any clock edge with cfg_wr_en high; it is
// meant to change only while the block is idle.
`default_nettype none

module length_prefixed_frame_splitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: maximum frame total including the length field.
	input  wire logic        cfg_wr_en,
	input  wire logic [16:0] cfg_wr_data,
	// Input channel.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,  // [0] kind
	// Output channel.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] msg_id, [23:16] payload_byte,
	                                        // [24] error_code, [31:25] zero
	output logic [1:0]       m_axis_tuser,  // [1:0] out_kind
	output logic             m_axis_tlast   // last_of_frame
);

	logic [16:0]        max_total_q;
	logic               in_fire;
	lpfs_pkg::q_item_t  q_push;
	lpfs_pkg::q_item_t  q_head;
	lpfs_pkg::q_stat_t  q_stat;
	logic               q_pop;
	lpfs_pkg::res_t     out_res;

	// The maximum frame total is a plain register with no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= lpfs_pkg::MAX_TOTAL_RST;
		end else if (cfg_wr_en) begin
			max_total_q <= cfg_wr_data;
		end
	end

	// Each accepted beat pushes at most one result, so room for one entry is
	// all the front part needs to take a beat.
	assign s_axis_tready = !q_stat.full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	lpfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_fire),
		.in_kind   (s_axis_tuser[0]),
		.in_byte   (s_axis_tdata),
		.max_total (max_total_q),
		.push      (q_push)
	);

	lpfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	lpfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {7'd0, out_res.code, out_res.data, out_res.id};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

	// A result must never be offered to a full queue, or it would be lost.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.vld |-> !q_stat.full)
		else $error("result pushed into a full queue");

	// A clear beat resets the parser and produces no result.
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (s_axis_tuser[0] == lpfs_pkg::IN_CLEAR) |-> !q_push.vld)
		else $error("clear beat produced a result");

	// An empty-frame result always closes its frame.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == lpfs_pkg::OK_EMPTY) |-> m_axis_tlast)
		else $error("empty-frame result without last flag");

	// An error result carries no id and does not close a frame.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == lpfs_pkg::OK_ERROR)
		|-> (m_axis_tdata[15:0] == 16'd0) && !m_axis_tlast)
		else $error("error result with id or last flag set");

endmodule

`default_nettype wire
